/* sv/kfs_pkg.sv */
// ----------------------------------------------------------------------------
// Keyframe sampler package
// Shared types, codes and constants of the keyframe track sampler.
// ----------------------------------------------------------------------------
package kfs_pkg;

   localparam int DefaultMaxKeys = 256;
   localparam logic [16:0] FacOne = 17'h10000;

   // Request codes.
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_RSVD  = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_SAMPLE  = 2'd0;
   localparam logic [1:0] ST_STORED  = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;
   localparam logic [1:0] ST_CLEARED = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [31:0]        key_time;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] key_z;
      logic [31:0]        sample_time;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [1:0]         status;
   } rsp_item_type;

   // Control between the sequencer and the divider.
   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [16:0] fac;
   } div_res_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_SRCH_WAIT,
      S_READ_I,
      S_READ_J,
      S_DIVIDE,
      S_MUL,
      S_SUM,
      S_OUT
   } state_type;

endpackage

/* sv/kfs_if.sv */
// ----------------------------------------------------------------------------
// Keyframe sampler channels
// Valid/ready channel interfaces for request and response items.
// ----------------------------------------------------------------------------
interface kfs_req_if;
   import kfs_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface kfs_rsp_if;
   import kfs_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/kfs_divider.sv */
// ----------------------------------------------------------------------------
// Keyframe sampler factor divider
// Restoring divider, one quotient bit per cycle, giving a Q1.16 factor; the caller saturates at 1.0.
// ----------------------------------------------------------------------------
module kfs_divider
   import kfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   // The quotient of (num << 16) / den needs only 17 bits after saturation,
   // and num < den guarantees that; otherwise the caller saturates anyway.
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [16:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, 1'b0} - {2'b00, den_ff};
      if (cmd.start) begin
         rem_in  = {1'b0, cmd.num};
         den_in  = cmd.den;
         quo_in  = '0;
         cnt_in  = 5'd15;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], 1'b0};
            quo_in = {quo_ff[15:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign res.done = done_ff;
   assign res.fac  = quo_ff;

endmodule

/* sv/vec3_keyframe_track_sampler_unit.sv */
// ----------------------------------------------------------------------------
// Keyframe track sampler
// Loads three-component keys into a key memory and samples them by linear
// interpolation between the two keys around the query time.
// ----------------------------------------------------------------------------
// Load and clear items are answered from the S_OUT state once accepted.
// A query does a linear scan of the time memory (one read per key), a
// bit-serial divide and three multiplies on a single shared multiplier.
// One item is worked on at a time. Reset clears the key count, the default
// register and the control state; the key memories are not cleared.
module vec3_keyframe_track_sampler_unit
   import kfs_pkg::*;
#(
   parameter int MAX_KEYS = DefaultMaxKeys
) (
   input  logic        clock,
   input  logic        reset,
   kfs_req_if.sink     req,
   kfs_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);

   // Key memories with registered reads.
   logic [31:0] time_mem [MAX_KEYS];
   logic [95:0] val_mem [MAX_KEYS];
   logic [31:0] time_rd_ff;
   logic [95:0] val_rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [31:0] dflt_ff;
   req_item_type  item_ff, item_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] seg_ff, seg_in;
   logic [31:0]   ti_ff, ti_in;
   logic [95:0]   vi_ff, vi_in, vj_ff, vj_in;
   logic [16:0]   fac_ff, fac_in;
   logic [1:0]    comp_ff, comp_in;
   logic signed [49:0] prod_ff, prod_in;
   rsp_item_type  out_ff, out_in;
   logic          ovalid_ff, ovalid_in;
   logic          busy_ff, busy_in;
   div_cmd_type   dcmd;
   div_res_type   dres;

   kfs_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .res(dres));

   // Memory port: one write for loads, one registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[count_ff[AW-1:0]] <= item_ff.key_time;
         val_mem[count_ff[AW-1:0]]  <= {item_ff.key_x, item_ff.key_y, item_ff.key_z};
      end
      time_rd_ff <= time_mem[rd_addr];
      val_rd_ff  <= val_mem[rd_addr];
   end

   // Component selection helpers.
   function automatic logic signed [31:0] comp_of(input logic [95:0] v,
                                                  input logic [1:0] c);
      logic signed [31:0] r;
      begin
         case (c)
            2'd0:    r = v[95:64];
            2'd1:    r = v[63:32];
            default: r = v[31:0];
         endcase
         return r;
      end
   endfunction

   logic signed [31:0] comp_a, comp_b;
   logic signed [32:0] diff;
   logic signed [33:0] sum;
   assign comp_a = comp_of(vi_ff, comp_ff);
   assign comp_b = comp_of(vj_ff, comp_ff);
   assign diff   = 33'(comp_b) - 33'(comp_a);
   // Arithmetic shift floors, matching the rounding toward minus infinity.
   assign sum    = 34'(comp_a) + 34'(prod_ff >>> 16);

   assign req.ready = !busy_ff && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      item_in   = item_ff;
      idx_in    = idx_ff;
      seg_in    = seg_ff;
      ti_in     = ti_ff;
      vi_in     = vi_ff;
      vj_in     = vj_ff;
      fac_in    = fac_ff;
      comp_in   = comp_ff;
      prod_in   = prod_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff;
      busy_in   = busy_ff;
      wr_en     = 1'b0;
      rd_addr   = idx_ff[AW-1:0];
      dcmd      = '0;
      if (rsp.valid && rsp.ready) ovalid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.payload;
               busy_in = 1'b1;
               state_in = S_OUT;
               out_in = '0;
               case (req.payload.req_type)
                  REQ_LOAD: begin
                     out_in.status = (count_ff < CW'(MAX_KEYS)) ? ST_STORED : ST_DROPPED;
                  end
                  REQ_QUERY: begin
                     out_in.status = ST_SAMPLE;
                     if (count_ff == '0) begin
                        out_in.out_x = dflt_ff;
                        out_in.out_y = dflt_ff;
                        out_in.out_z = dflt_ff;
                     end else begin
                        idx_in   = CW'(1);
                        seg_in   = AW'(count_ff - CW'(1));
                        state_in = (count_ff == CW'(1)) ? S_READ_I : S_SEARCH;
                     end
                  end
                  default: begin
                     out_in.status = ST_CLEARED;
                     count_in = '0;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // Read key idx; its time arrives next cycle.
            rd_addr  = idx_ff[AW-1:0];
            state_in = S_SRCH_WAIT;
         end
         S_SRCH_WAIT: begin
            if (item_ff.sample_time < time_rd_ff) begin
               seg_in   = AW'(idx_ff - CW'(1));
               state_in = S_READ_I;
               idx_in   = '0;
            end else if (idx_ff + CW'(1) >= count_ff) begin
               state_in = S_READ_I;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SEARCH;
            end
         end
         S_READ_I: begin
            rd_addr  = seg_ff;
            state_in = S_READ_J;
         end
         S_READ_J: begin
            ti_in = time_rd_ff;
            vi_in = val_rd_ff;
            if (32'(seg_ff) + 32'd1 < 32'(count_ff)) rd_addr = seg_ff + AW'(1);
            else rd_addr = seg_ff;
            state_in = S_DIVIDE;
            idx_in   = '0;
         end
         S_DIVIDE: begin
            if (idx_ff == '0) begin
               vj_in  = val_rd_ff;
               idx_in = CW'(1);
               if (time_rd_ff > ti_ff && item_ff.sample_time >= ti_ff) begin
                  if (item_ff.sample_time - ti_ff >= time_rd_ff - ti_ff) begin
                     fac_in = FacOne;
                     state_in = S_MUL;
                  end else begin
                     dcmd.start = 1'b1;
                     dcmd.num   = item_ff.sample_time - ti_ff;
                     dcmd.den   = time_rd_ff - ti_ff;
                  end
               end else begin
                  fac_in = '0;
                  state_in = S_MUL;
               end
               comp_in = '0;
            end else if (dres.done) begin
               fac_in = dres.fac;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = 50'(diff) * 50'($signed({1'b0, fac_ff}));
            state_in = S_SUM;
         end
         S_SUM: begin
            case (comp_ff)
               2'd0:    out_in.out_x = sum[31:0];
               2'd1:    out_in.out_y = sum[31:0];
               default: out_in.out_z = sum[31:0];
            endcase
            comp_in  = comp_ff + 2'd1;
            state_in = (comp_ff == 2'd2) ? S_OUT : S_MUL;
         end
         S_OUT: begin
            if (item_ff.req_type == REQ_LOAD && count_ff < CW'(MAX_KEYS)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
            ovalid_in = 1'b1;
            busy_in   = 1'b0;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         dflt_ff   <= '0;
         ovalid_ff <= 1'b0;
         busy_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
         busy_ff   <= busy_in;
         if (csr_we) dflt_ff <= csr_wdata;
      end
      item_ff <= item_in;
      idx_ff  <= idx_in;
      seg_ff  <= seg_in;
      ti_ff   <= ti_in;
      vi_ff   <= vi_in;
      vj_ff   <= vj_in;
      fac_ff  <= fac_in;
      comp_ff <= comp_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEYS)) else $error("key count beyond capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.ready) else $error("accepted while busy");
   a_fac_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> fac_ff <= FacOne) else $error("factor above one");
   a_out_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> ovalid_ff) else $error("response not raised");
`endif

endmodule
